>>> design/efsd_pkg.sv
// Shared types and constants of the earliest-free server dispatch unit.
package efsd_pkg;

    // Field widths
    localparam int TIME_W      = 40;
    localparam int DUR_W       = 16;
    localparam int SRV_W       = 5;
    localparam int CFG_W       = 5;
    localparam int IN_TDATA_W  = 16;
    localparam int IN_TUSER_W  = 1;
    localparam int OUT_TDATA_W = 56;

    // Reset value of the servers-in-use register
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    // Item kinds carried in tuser
    localparam logic MODE_JOB   = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;

    // Sequencer states, one-hot
    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_SCAN    = 7'b0000010,
        S_LAST    = 7'b0000100,
        S_ADD     = 7'b0001000,
        S_WRITE   = 7'b0010000,
        S_CLEAR   = 7'b0100000,
        S_CLRDONE = 7'b1000000
    } t_state;

endpackage

>>> design/earliest_free_server_dispatch_unit.sv
// Top level of the earliest-free server dispatch unit.
// Keeps one free time per server in a single-port synchronous memory and hands each
// job to the active server that frees earliest (lowest number on ties). A job is
// accepted in the idle state, the memory's one read port streams the free times of
// the N servers in use into the min/second-min tracker, the last word is compared,
// the saturating add is done, and the write-back also loads the result register,
// waiting while that register holds a result not yet taken.
// A clear item sweeps every memory entry, one per cycle.
// After reset the same sweep runs, during which no item is accepted; configuration
// writes are taken at any time. One result is held in an output register, so the next
// item is accepted while a result waits to be taken.
module earliest_free_server_dispatch_unit #(
    parameter int MAX_LANES = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration channel: servers_in_use
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [efsd_pkg::CFG_W-1:0]         i_cfg_data,
    // Input stream
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [efsd_pkg::IN_TDATA_W-1:0]    i_s_tdata,  // [15:0] service_time
    input  logic [efsd_pkg::IN_TUSER_W-1:0]    i_s_tuser,  // [0] mode
    // Output stream
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // [4:0] assigned_server, [44:5] start_time, [49:45] next_server, [55:50] zero
    output logic [efsd_pkg::OUT_TDATA_W-1:0]   o_m_tdata
);

    localparam int IW = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1;
    localparam logic [IW-1:0] LAST_ADDR = IW'(MAX_LANES - 1);

    efsd_pkg::t_state r_state, n_state;

    logic [efsd_pkg::CFG_W-1:0]  r_servers_in_use;
    logic [IW-1:0]               w_last;

    // Free-time memory
    logic [efsd_pkg::TIME_W-1:0] r_mem [MAX_LANES];
    logic [efsd_pkg::TIME_W-1:0] r_rd_data;
    logic                        w_we;
    logic [IW-1:0]               w_wa;
    logic [efsd_pkg::TIME_W-1:0] w_wd;
    logic                        w_re;

    // Scan control and trackers
    logic [IW-1:0]               r_addr;
    logic                        r_cmp_vld;
    logic [IW-1:0]               r_cmp_idx;
    logic                        r_clr_emit;
    logic [efsd_pkg::DUR_W-1:0]  r_dur;
    logic [efsd_pkg::TIME_W-1:0] r_best;
    logic [IW-1:0]               r_best_idx;
    logic [efsd_pkg::TIME_W-1:0] r_sec;
    logic [IW-1:0]               r_sec_idx;
    logic                        r_sec_vld;
    logic [efsd_pkg::TIME_W-1:0] r_finish;
    logic [efsd_pkg::TIME_W:0]   w_sum;

    // Result register
    logic                        r_out_vld;
    logic [efsd_pkg::SRV_W-1:0]  r_out_asg;
    logic [efsd_pkg::TIME_W-1:0] r_out_start;
    logic [efsd_pkg::SRV_W-1:0]  r_out_next;
    logic                        w_out_free;
    logic                        w_s_acc;
    logic                        w_emit;
    logic [IW-1:0]               w_next_idx;
    logic [IW:0]                 w_asg_num;
    logic [IW:0]                 w_next_num;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == efsd_pkg::S_IDLE);
    assign w_s_acc     = i_s_tvalid && o_s_tready;
    assign w_out_free  = !r_out_vld || i_m_tready;
    assign o_m_tvalid  = r_out_vld;
    assign o_m_tdata   = {{(efsd_pkg::OUT_TDATA_W - 2 * efsd_pkg::SRV_W - efsd_pkg::TIME_W){1'b0}},
                          r_out_next, r_out_start, r_out_asg};

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_servers_in_use <= efsd_pkg::CFG_RESET;
        end else if (i_cfg_valid) begin
            r_servers_in_use <= i_cfg_data;
        end
    end

    // Last active server index, count clamped to 1..MAX_LANES
    always_comb begin
        if (r_servers_in_use == '0) begin
            w_last = '0;
        end else if (32'(r_servers_in_use) >= 32'(MAX_LANES)) begin
            w_last = LAST_ADDR;
        end else begin
            w_last = IW'(r_servers_in_use - 5'd1);
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            efsd_pkg::S_IDLE: begin
                if (w_s_acc) begin
                    n_state = (i_s_tuser[0] == efsd_pkg::MODE_CLEAR) ? efsd_pkg::S_CLEAR
                                                                     : efsd_pkg::S_SCAN;
                end
            end
            efsd_pkg::S_SCAN: begin
                if (r_addr == w_last) begin
                    n_state = efsd_pkg::S_LAST;
                end
            end
            efsd_pkg::S_LAST:  n_state = efsd_pkg::S_ADD;
            efsd_pkg::S_ADD:   n_state = efsd_pkg::S_WRITE;
            efsd_pkg::S_WRITE: begin
                if (w_out_free) begin
                    n_state = efsd_pkg::S_IDLE;
                end
            end
            efsd_pkg::S_CLEAR: begin
                if (r_addr == LAST_ADDR) begin
                    n_state = r_clr_emit ? efsd_pkg::S_CLRDONE : efsd_pkg::S_IDLE;
                end
            end
            efsd_pkg::S_CLRDONE: begin
                if (w_out_free) begin
                    n_state = efsd_pkg::S_IDLE;
                end
            end
            default: n_state = efsd_pkg::S_IDLE;
        endcase
    end

    // State, address counter and clear flag; reset starts the clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= efsd_pkg::S_CLEAR;
            r_addr     <= '0;
            r_clr_emit <= 1'b0;
            r_cmp_vld  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= (r_state == efsd_pkg::S_SCAN);
            case (r_state)
                efsd_pkg::S_IDLE: begin
                    r_addr     <= '0;
                    r_clr_emit <= 1'b1;
                end
                efsd_pkg::S_SCAN,
                efsd_pkg::S_CLEAR: begin
                    r_addr <= r_addr + IW'(1);
                end
                default: begin
                    r_addr <= r_addr;
                end
            endcase
        end
    end

    // Job duration capture
    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_dur <= i_s_tdata;
        end
    end

    // Memory port control
    assign w_re = (r_state == efsd_pkg::S_SCAN);
    assign w_emit = (r_state == efsd_pkg::S_WRITE) && w_out_free;
    always_comb begin
        w_we = 1'b0;
        w_wa = r_addr;
        w_wd = '0;
        if (r_state == efsd_pkg::S_CLEAR) begin
            w_we = 1'b1;
        end else if (w_emit) begin
            w_we = 1'b1;
            w_wa = r_best_idx;
            w_wd = r_finish;
        end
    end

    // Free-time memory, registered read
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        if (w_re) begin
            r_rd_data <= r_mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_re) begin
            r_cmp_idx <= r_addr;
        end
    end

    // Earliest and second-earliest tracker, lowest index wins ties
    always_ff @(posedge i_clk) begin
        if (r_cmp_vld) begin
            if (r_cmp_idx == '0) begin
                r_best     <= r_rd_data;
                r_best_idx <= r_cmp_idx;
                r_sec_vld  <= 1'b0;
            end else if (r_rd_data < r_best) begin
                r_sec      <= r_best;
                r_sec_idx  <= r_best_idx;
                r_sec_vld  <= 1'b1;
                r_best     <= r_rd_data;
                r_best_idx <= r_cmp_idx;
            end else if (!r_sec_vld || (r_rd_data < r_sec)) begin
                r_sec      <= r_rd_data;
                r_sec_idx  <= r_cmp_idx;
                r_sec_vld  <= 1'b1;
            end
        end
    end

    // Saturating finish time
    assign w_sum = {1'b0, r_best} + {{(efsd_pkg::TIME_W + 1 - efsd_pkg::DUR_W){1'b0}}, r_dur};
    always_ff @(posedge i_clk) begin
        if (r_state == efsd_pkg::S_ADD) begin
            r_finish <= w_sum[efsd_pkg::TIME_W] ? {efsd_pkg::TIME_W{1'b1}}
                                                : w_sum[efsd_pkg::TIME_W-1:0];
        end
    end

    // Server for the following job: updated server against the runner-up
    always_comb begin
        if (!r_sec_vld || (r_finish < r_sec)) begin
            w_next_idx = r_best_idx;
        end else if (r_sec < r_finish) begin
            w_next_idx = r_sec_idx;
        end else begin
            w_next_idx = (r_sec_idx < r_best_idx) ? r_sec_idx : r_best_idx;
        end
    end

    assign w_asg_num  = {1'b0, r_best_idx} + (IW + 1)'(1);
    assign w_next_num = {1'b0, w_next_idx} + (IW + 1)'(1);

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_emit || ((r_state == efsd_pkg::S_CLRDONE) && w_out_free)) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_asg   <= efsd_pkg::SRV_W'(w_asg_num);
            r_out_start <= r_best;
            r_out_next  <= efsd_pkg::SRV_W'(w_next_num);
        end else if ((r_state == efsd_pkg::S_CLRDONE) && w_out_free) begin
            r_out_asg   <= '0;
            r_out_start <= '0;
            r_out_next  <= efsd_pkg::SRV_W'(1);
        end
    end

    // Checks
    a_we_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == efsd_pkg::S_WRITE || r_state == efsd_pkg::S_CLEAR))
        else $error("memory written outside write-back or clear sweep");

    a_cmp_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmp_vld |-> (r_state == efsd_pkg::S_SCAN || r_state == efsd_pkg::S_LAST))
        else $error("read data compared outside the scan");

    a_best_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == efsd_pkg::S_WRITE) |-> (r_best_idx <= w_last))
        else $error("selected server is not active");

    a_sec_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == efsd_pkg::S_WRITE && r_sec_vld) |-> (r_sec_idx != r_best_idx))
        else $error("runner-up equals selected server");

    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> r_out_vld)
        else $error("write-back did not produce a result");

endmodule

>>> tb/tb_earliest_free_server_dispatch_unit.sv
// Self-checking testbench for the earliest-free server dispatch unit.
`timescale 1ns / 100ps

module tb_earliest_free_server_dispatch_unit;

    localparam int MAX_LANES  = 16;
    localparam int SEGMENTS   = 10;
    localparam int SEG_JOBS   = 123;
    localparam int DRAIN_WAIT = MAX_LANES + 16;
    localparam int CYCLE_CAP  = 600000;

    typedef struct packed {
        logic                        mode;
        logic [efsd_pkg::DUR_W-1:0]  service_time;
    } t_job;

    typedef struct packed {
        logic [efsd_pkg::SRV_W-1:0]  assigned_server;
        logic [efsd_pkg::TIME_W-1:0] start_time;
        logic [efsd_pkg::SRV_W-1:0]  next_server;
    } t_grant;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             cfg_valid = 1'b0;
    logic [efsd_pkg::CFG_W-1:0]       cfg_data = '0;
    logic                             o_cfg_ready;
    logic                             s_tvalid = 1'b0;
    logic [efsd_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
    logic [efsd_pkg::IN_TUSER_W-1:0]  s_tuser = '0;
    logic                             o_s_tready;
    logic                             o_m_tvalid;
    logic                             m_tready = 1'b0;
    logic [efsd_pkg::OUT_TDATA_W-1:0] o_m_tdata;

    // Predictor state: free time per server and the servers-in-use register
    logic [efsd_pkg::TIME_W-1:0] free_time_q [MAX_LANES];
    logic [efsd_pkg::CFG_W-1:0]  servers_in_use_q = efsd_pkg::CFG_RESET;

    t_job   job_queue [$];
    t_grant pending_grants [$];
    bit     s_taken = 1'b0;
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    int     error_count = 0;
    int     cycle_count = 0;

    earliest_free_server_dispatch_unit #(
        .MAX_LANES (MAX_LANES)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_tdata),    // [15:0] service_time
        .i_s_tuser   (s_tuser),    // [0] mode
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_tready),
        // [4:0] assigned_server, [44:5] start_time, [49:45] next_server, [55:50] zero
        .o_m_tdata   (o_m_tdata)
    );

    always #4 i_clk = ~i_clk;

    initial begin
        for (int i = 0; i < MAX_LANES; i++) free_time_q[i] = '0;
    end

    // Count of servers taking part; out-of-range register values are clamped
    function automatic int lanes_active();
        int n;
        n = int'(servers_in_use_q);
        if (n < 1) n = 1;
        if (n > MAX_LANES) n = MAX_LANES;
        return n;
    endfunction

    // Lowest-numbered active server with the smallest free time (index from 0)
    function automatic int earliest_lane();
        int best;
        best = 0;
        for (int i = 1; i < lanes_active(); i++)
            if (free_time_q[i] < free_time_q[best]) best = i;
        return best;
    endfunction

    // Dispatch one job (or clear) against the predictor state
    function automatic t_grant dispatch_job(t_job j);
        t_grant                     g;
        int                         sel;
        logic [efsd_pkg::TIME_W:0]  sum;
        if (j.mode == efsd_pkg::MODE_CLEAR) begin
            for (int i = 0; i < MAX_LANES; i++) free_time_q[i] = '0;
            g.assigned_server = '0;
            g.start_time      = '0;
            g.next_server     = efsd_pkg::SRV_W'(1);
            return g;
        end
        sel = earliest_lane();
        g.assigned_server = efsd_pkg::SRV_W'(sel + 1);
        g.start_time      = free_time_q[sel];
        sum = {1'b0, free_time_q[sel]} + (efsd_pkg::TIME_W + 1)'(j.service_time);
        // Saturate at the top of the time range
        free_time_q[sel] = sum[efsd_pkg::TIME_W] ? {efsd_pkg::TIME_W{1'b1}}
                                                 : sum[efsd_pkg::TIME_W-1:0];
        g.next_server = efsd_pkg::SRV_W'(earliest_lane() + 1);
        return g;
    endfunction

    // Driver: next transaction once the current one is taken, random gaps
    always @(negedge i_clk) begin
        t_job j;
        if (!s_tvalid || s_taken) begin
            if (job_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                j = job_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= j.mode;
                s_tdata  <= j.service_time;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Monitor: predict on input transactions, check output transactions
    always @(posedge i_clk) begin
        t_job   j;
        t_grant exp_g;
        s_taken = s_tvalid && o_s_tready && i_rst_n;
        if (i_rst_n) begin
            if (cfg_valid && o_cfg_ready) servers_in_use_q = cfg_data;
            if (s_taken) begin
                j.mode         = s_tuser[0];
                j.service_time = s_tdata;
                pending_grants.push_back(dispatch_job(j));
            end
            if (o_m_tvalid && m_tready) begin
                if (pending_grants.size() == 0) begin
                    $error("unexpected result transaction: tdata %h", o_m_tdata);
                    error_count++;
                end else begin
                    exp_g = pending_grants.pop_front();
                    if (o_m_tdata[4:0] !== exp_g.assigned_server) begin
                        $error("assigned_server: expected %0d, got %0d",
                               exp_g.assigned_server, o_m_tdata[4:0]);
                        error_count++;
                    end
                    if (o_m_tdata[44:5] !== exp_g.start_time) begin
                        $error("start_time: expected %0d, got %0d",
                               exp_g.start_time, o_m_tdata[44:5]);
                        error_count++;
                    end
                    if (o_m_tdata[49:45] !== exp_g.next_server) begin
                        $error("next_server: expected %0d, got %0d",
                               exp_g.next_server, o_m_tdata[49:45]);
                        error_count++;
                    end
                    if (o_m_tdata[55:50] !== 6'd0) begin
                        $error("padding: expected 0, got %h", o_m_tdata[55:50]);
                        error_count++;
                    end
                end
            end
        end
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic push_job(input logic mode, input logic [efsd_pkg::DUR_W-1:0] dur);
        t_job j;
        j.mode         = mode;
        j.service_time = dur;
        job_queue.push_back(j);
    endtask

    // Hold until every queued job is sent and every grant has come back
    task automatic wait_drained();
        while (job_queue.size() > 0 || s_tvalid || pending_grants.size() > 0)
            @(posedge i_clk);
    endtask

    task automatic write_servers_in_use(input logic [efsd_pkg::CFG_W-1:0] v);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // Random job: mostly dispatches, occasionally a clear
    task automatic push_random_job();
        logic [efsd_pkg::DUR_W-1:0] dur;
        case ($urandom_range(3))
            0: dur = efsd_pkg::DUR_W'($urandom_range(15));
            1: dur = efsd_pkg::DUR_W'($urandom);
            2: dur = $urandom_range(1) ? {efsd_pkg::DUR_W{1'b1}} : '0;
            default: dur = efsd_pkg::DUR_W'($urandom_range(300));
        endcase
        if ($urandom_range(99) < 3) push_job(efsd_pkg::MODE_CLEAR, dur);
        else push_job(efsd_pkg::MODE_JOB, dur);
    endtask

    initial begin
        logic [efsd_pkg::CFG_W-1:0] seg_cfg [SEGMENTS];
        seg_cfg = '{5'd1, 5'd0, 5'd31, 5'd16, 5'd5, 5'd17, 5'd2, 5'd8, 5'd12, 5'd16};
        seg_cfg[SEGMENTS-1] = efsd_pkg::CFG_W'($urandom_range(1, MAX_LANES));

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 33;
        recv_idle_pct = 52;

        // Directed: reset setting of 16 servers, field extremes, ties, clears
        push_job(efsd_pkg::MODE_JOB, 16'h0000);
        push_job(efsd_pkg::MODE_JOB, 16'hFFFF);
        push_job(efsd_pkg::MODE_JOB, 16'h0001);
        push_job(efsd_pkg::MODE_JOB, 16'h5555);
        push_job(efsd_pkg::MODE_JOB, 16'hAAAA);
        push_job(efsd_pkg::MODE_JOB, 16'h0000);
        push_job(efsd_pkg::MODE_CLEAR, 16'hFFFF);
        push_job(efsd_pkg::MODE_JOB, 16'h0007);
        push_job(efsd_pkg::MODE_JOB, 16'h0007);
        push_job(efsd_pkg::MODE_JOB, 16'h0007);
        push_job(efsd_pkg::MODE_CLEAR, 16'h0000);
        push_job(efsd_pkg::MODE_JOB, 16'h0000);
        wait_drained();

        // Directed: register of zero acts as one server
        write_servers_in_use(5'd0);
        push_job(efsd_pkg::MODE_JOB, 16'h0005);
        push_job(efsd_pkg::MODE_JOB, 16'hFFFF);
        push_job(efsd_pkg::MODE_JOB, 16'h0000);
        wait_drained();

        // Directed: register above the lane count acts as all lanes,
        // lanes idle while disabled come back with their old times
        write_servers_in_use(5'd31);
        push_job(efsd_pkg::MODE_JOB, 16'h0003);
        push_job(efsd_pkg::MODE_JOB, 16'h0002);
        push_job(efsd_pkg::MODE_JOB, 16'h0001);
        wait_drained();
        write_servers_in_use(5'd2);
        push_job(efsd_pkg::MODE_JOB, 16'h0004);
        push_job(efsd_pkg::MODE_JOB, 16'h0004);
        push_job(efsd_pkg::MODE_CLEAR, 16'h1234);
        wait_drained();

        // Random segments, one register setting each
        for (int s = 0; s < SEGMENTS; s++) begin
            if (s == 4) begin
                send_idle_pct = 52;
                recv_idle_pct = 33;
            end else if (s == 7) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_servers_in_use(seg_cfg[s]);
            for (int k = 0; k < SEG_JOBS; k++) push_random_job();
            wait_drained();
        end

        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (pending_grants.size() != 0) begin
            $error("%0d grants never arrived", pending_grants.size());
            error_count++;
        end
        if (error_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> earliest_free_server_dispatch_unit.f
design/efsd_pkg.sv
design/earliest_free_server_dispatch_unit.sv
tb/tb_earliest_free_server_dispatch_unit.sv
